// ----- design/dlt_pkg.sv -----
// Shared types and constants of the delta-list timer queue.
package dlt_pkg;

    localparam int SLOT_W          = 4;
    localparam int DELTA_W         = 32;
    localparam int OWNER_W         = 13;
    localparam int DEF_TIMER_SLOTS = 16;
    localparam int MAX_RESULTS     = 16;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ADD  = 2'd1,
        OP_DEL  = 2'd2,
        OP_RSVD = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_REMOVED    = 3'd1,
        ST_NOT_QUEUED = 3'd2,
        ST_REJECTED   = 3'd3,
        ST_EXPIRED    = 3'd4,
        ST_NO_EXPIRY  = 3'd5
    } status_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [SLOT_W-1:0]    timer_slot;
        logic [DELTA_W-1:0]   delay_ticks;
        logic [OWNER_W-1:0]   owner_id;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    expired_slot;
        logic [OWNER_W-1:0]   wake_owner;
        logic                 last;
    } out_item_t;

    // One queue position.
    typedef struct packed {
        logic                 valid;
        logic [SLOT_W-1:0]    slot;
        logic [DELTA_W-1:0]   delta;
        logic [OWNER_W-1:0]   owner;
    } entry_t;

    localparam entry_t ENTRY_NONE = '{valid: 1'b0, slot: '0, delta: '0, owner: '0};

    typedef enum logic [2:0] {
        CK_NONE   = 3'd0,
        CK_SEARCH = 3'd1,
        CK_PUSH   = 3'd2,
        CK_FIND   = 3'd3,
        CK_PULL   = 3'd4
    } carry_kind_t;

    // Token that travels from cell to cell, one cell per cycle.
    typedef struct packed {
        carry_kind_t          kind;
        logic [DELTA_W-1:0]   value;
        logic [SLOT_W-1:0]    slot;
        logic [OWNER_W-1:0]   owner;
    } carry_t;

    typedef struct packed {
        logic shl;
        logic dec;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_WALK      = 3'd1,
        S_TICK_DEC  = 3'd2,
        S_TICK_SCAN = 3'd3,
        S_RESP      = 3'd4
    } state_t;

endpackage

// ----- design/dlt_cell.sv -----
// One queue position of the timer chain with its token register.
module dlt_cell
    import dlt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cell_cmd_t cmd,
    input  carry_t    carry_in,
    input  entry_t    right_entry,
    output entry_t    entry,
    output carry_t    carry_out
);

    entry_t entry_reg, entry_next;
    carry_t carry_reg, carry_next;

    always_comb begin
        entry_next      = entry_reg;
        carry_next      = carry_in;
        carry_next.kind = CK_NONE;
        if (cmd.shl) begin
            entry_next = right_entry;
        end else if (cmd.dec) begin
            if (entry_reg.delta != '0) begin
                entry_next.delta = entry_reg.delta - DELTA_W'(1);
            end
        end else begin
            case (carry_in.kind)
                CK_SEARCH: begin
                    if (!entry_reg.valid) begin
                        entry_next = '{valid: 1'b1, slot: carry_in.slot,
                                       delta: carry_in.value, owner: carry_in.owner};
                    end else if (carry_in.value < entry_reg.delta) begin
                        // New timer goes here; the old occupant ripples one place back.
                        entry_next = '{valid: 1'b1, slot: carry_in.slot,
                                       delta: carry_in.value, owner: carry_in.owner};
                        carry_next = '{kind: CK_PUSH, value: entry_reg.delta - carry_in.value,
                                       slot: entry_reg.slot, owner: entry_reg.owner};
                    end else begin
                        carry_next.kind  = CK_SEARCH;
                        carry_next.value = carry_in.value - entry_reg.delta;
                    end
                end
                CK_PUSH: begin
                    entry_next = '{valid: 1'b1, slot: carry_in.slot,
                                   delta: carry_in.value, owner: carry_in.owner};
                    if (entry_reg.valid) begin
                        carry_next = '{kind: CK_PUSH, value: entry_reg.delta,
                                       slot: entry_reg.slot, owner: entry_reg.owner};
                    end
                end
                CK_FIND: begin
                    if (entry_reg.valid && entry_reg.slot == carry_in.slot) begin
                        // The follower inherits the removed delta.
                        entry_next = right_entry;
                        if (right_entry.valid) begin
                            entry_next.delta = right_entry.delta + entry_reg.delta;
                        end
                        carry_next.kind = CK_PULL;
                    end else begin
                        carry_next.kind = CK_FIND;
                    end
                end
                CK_PULL: begin
                    entry_next = right_entry;
                    if (entry_reg.valid) begin
                        carry_next.kind = CK_PULL;
                    end
                end
                default: begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
            carry_reg.kind  <= CK_NONE;
        end else begin
            entry_reg <= entry_next;
            carry_reg <= carry_next;
        end
    end

    assign entry     = entry_reg;
    assign carry_out = carry_reg;

endmodule

// ----- design/dlt_ctrl.sv -----
// Request decode, tick sequencing and result register of the timer queue.
module dlt_ctrl
    import dlt_pkg::*;
#(
    parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item,
    input  entry_t    head,
    input  entry_t    second,
    input  logic      full,
    output carry_t    inj,
    output cell_cmd_t cmd
);

    localparam int FLAG_N = (TIMER_SLOTS < (1 << SLOT_W)) ? TIMER_SLOTS : (1 << SLOT_W);
    localparam int FIDX_W = (FLAG_N > 1) ? $clog2(FLAG_N) : 1;
    localparam int CNT_W  = $clog2(TIMER_SLOTS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIMER_SLOTS - 1);
    localparam int NCNT_W = $clog2(MAX_RESULTS);
    localparam logic [NCNT_W-1:0] N_LAST = NCNT_W'(MAX_RESULTS - 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [NCNT_W-1:0]   n_reg, n_next;
    logic [FLAG_N-1:0]   flags_reg, flags_next;
    carry_t              inj_reg, inj_next;
    status_t             resp_reg, resp_next;
    out_item_t           out_reg, out_data;
    logic                out_valid_reg;
    logic                out_load;

    logic                accept;
    logic                in_range;
    logic [FIDX_W-1:0]   in_idx;
    logic [FIDX_W-1:0]   head_idx;
    logic                flag_hit;
    logic                add_ok;
    logic                expire;
    logic                last_exp;
    logic                out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_range = (32'(s_item.timer_slot) < 32'(TIMER_SLOTS));
    assign in_idx   = s_item.timer_slot[FIDX_W-1:0];
    assign head_idx = head.slot[FIDX_W-1:0];
    assign flag_hit = in_range && flags_reg[in_idx];
    assign add_ok   = (s_item.delay_ticks != '0) && in_range && !flag_hit && !full;
    assign expire   = head.valid && (head.delta == '0);
    // Last expiry of a tick: no due entry behind the head, or MAX_RESULTS.
    assign last_exp = (n_reg == N_LAST) || !second.valid || (second.delta != '0);
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_item.opcode)
                        OP_TICK: state_next = head.valid ? S_TICK_DEC : S_RESP;
                        OP_ADD:  state_next = add_ok ? S_WALK : S_RESP;
                        OP_DEL:  state_next = flag_hit ? S_WALK : S_RESP;
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_WALK: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_RESP;
                end
            end
            S_TICK_DEC: begin
                state_next = S_TICK_SCAN;
            end
            S_TICK_SCAN: begin
                if (!expire) begin
                    state_next = S_RESP;
                end else if (out_free && last_exp) begin
                    state_next = S_IDLE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        flags_next    = flags_reg;
        inj_next      = inj_reg;
        inj_next.kind = CK_NONE;
        resp_next     = resp_reg;
        cmd           = '0;
        out_load      = 1'b0;
        out_data      = '{status: ST_ADDED, expired_slot: '0, wake_owner: '0, last: 1'b1};
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cnt_next = '0;
                    n_next   = '0;
                    case (s_item.opcode)
                        OP_TICK: begin
                            resp_next = ST_NO_EXPIRY;
                        end
                        OP_ADD: begin
                            if (add_ok) begin
                                resp_next          = ST_ADDED;
                                flags_next[in_idx] = 1'b1;
                                inj_next = '{kind: CK_SEARCH, value: s_item.delay_ticks,
                                             slot: s_item.timer_slot, owner: s_item.owner_id};
                            end else begin
                                resp_next = ST_REJECTED;
                            end
                        end
                        OP_DEL: begin
                            if (flag_hit) begin
                                resp_next          = ST_REMOVED;
                                flags_next[in_idx] = 1'b0;
                                inj_next.kind      = CK_FIND;
                                inj_next.slot      = s_item.timer_slot;
                            end else begin
                                resp_next = ST_NOT_QUEUED;
                            end
                        end
                        default: begin
                            resp_next = ST_REJECTED;
                        end
                    endcase
                end
            end
            S_WALK: begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_TICK_DEC: begin
                cmd.dec = 1'b1;
            end
            S_TICK_SCAN: begin
                if (expire && out_free) begin
                    out_load             = 1'b1;
                    out_data             = '{status: ST_EXPIRED, expired_slot: head.slot,
                                             wake_owner: head.owner, last: last_exp};
                    cmd.shl              = 1'b1;
                    flags_next[head_idx] = 1'b0;
                    n_next               = n_reg + NCNT_W'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_data.status = resp_reg;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            flags_reg     <= '0;
            inj_reg.kind  <= CK_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            flags_reg <= flags_next;
            inj_reg   <= inj_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        n_reg    <= n_next;
        resp_reg <= resp_next;
        if (out_load) begin
            out_reg <= out_data;
        end
    end

    assign inj     = inj_reg;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten while still waiting");

    a_shift_on_expiry: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shl |-> (head.valid && head.delta == '0 && state_reg == S_TICK_SCAN))
        else $error("queue shifted without an expired head");

    a_empty_tick_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK_SCAN && !expire) |-> (n_reg == '0))
        else $error("tick ended without marking its last expiry");

endmodule

// ----- design/delta_list_timer_queue.sv -----
// Top level of the delta-list timer queue: controller and chain of queue cells.
// Requests are taken one at a time. Successful adds and deletes walk S_WALK while the token
// passes the chain, then answer from S_RESP; a new request waits until the result is loaded.
// The insert or remove token walks the cell chain one cell per cycle.
// A tick answers from S_RESP on an empty queue, and after S_TICK_DEC when nothing expires;
// else its expiries leave from S_TICK_SCAN, one per cycle while the result register is free.
// Synchronous active-low reset empties the queue at once; no clearing pass is needed.
module delta_list_timer_queue
    import dlt_pkg::*;
#(
    parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam logic [TIMER_SLOTS-1:0] ONE_V = TIMER_SLOTS'(1);

    entry_t                 ent   [TIMER_SLOTS];
    carry_t                 chain [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] valid_vec;
    carry_t                 inj;
    cell_cmd_t              cmd;

    dlt_ctrl #(
        .TIMER_SLOTS(TIMER_SLOTS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .head    (ent[0]),
        .second  (ent[1]),
        .full    (ent[TIMER_SLOTS-1].valid),
        .inj     (inj),
        .cmd     (cmd)
    );

    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
        carry_t    c_in;
        entry_t    r_ent;
        cell_cmd_t c_cmd;

        if (i == 0) begin : g_first
            assign c_in = inj;
        end else begin : g_mid
            assign c_in = chain[i-1];
        end

        if (i == TIMER_SLOTS - 1) begin : g_tail
            assign r_ent = ENTRY_NONE;
        end else begin : g_body
            assign r_ent = ent[i+1];
        end

        // Only the head position counts down on a tick.
        assign c_cmd.shl = cmd.shl;
        assign c_cmd.dec = cmd.dec && (i == 0);

        dlt_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (c_cmd),
            .carry_in    (c_in),
            .right_entry (r_ent),
            .entry       (ent[i]),
            .carry_out   (chain[i])
        );

        assign valid_vec[i] = ent[i].valid;
    end

    a_compact_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> ((valid_vec & (valid_vec + ONE_V)) == '0))
        else $error("queue has a hole between occupied positions");

    a_no_spill: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[TIMER_SLOTS-1].kind != CK_PUSH && chain[TIMER_SLOTS-1].kind != CK_SEARCH)
        else $error("timer entry pushed off the end of the chain");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the delta-list timer queue with a built-in scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import dlt_pkg::*;

    localparam int TIMER_SLOTS = DEF_TIMER_SLOTS;
    localparam int RANDOM_REQUESTS = 84;
    localparam int DRAIN_CYCLES = 40;

    // Software copy of the timer queue; predicts the results of every accepted request.
    class timer_queue_scoreboard;
        logic [DELTA_W-1:0] delta_of [TIMER_SLOTS];
        logic [OWNER_W-1:0] owner_of [TIMER_SLOTS];
        logic [SLOT_W-1:0]  order [TIMER_SLOTS];
        logic [TIMER_SLOTS-1:0] queued_mask;
        int depth;
        out_item_t pending [$];
        int errors;

        function new();
            queued_mask = '0;
            depth = 0;
            errors = 0;
        endfunction

        function void push_result(status_t st, logic [SLOT_W-1:0] slot,
                                  logic [OWNER_W-1:0] own, logic lst);
            out_item_t r;
            r.status = st;
            r.expired_slot = slot;
            r.wake_owner = own;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function void remove_at(int pos);
            for (int i = pos; i + 1 < depth; i++) begin
                order[i] = order[i + 1];
            end
            depth--;
        endfunction

        function void note_request(in_item_t req);
            int pos;
            int n;
            logic [SLOT_W-1:0] s;
            logic [DELTA_W-1:0] rest;
            case (req.opcode)
                OP_TICK: begin
                    if (depth == 0) begin
                        push_result(ST_NO_EXPIRY, '0, '0, 1'b1);
                        return;
                    end
                    s = order[0];
                    if (delta_of[s] != '0) begin
                        delta_of[s] = delta_of[s] - 1'b1;
                    end
                    n = 0;
                    while (depth > 0 && n < MAX_RESULTS) begin
                        s = order[0];
                        if (delta_of[s] != '0) break;
                        push_result(ST_EXPIRED, s, owner_of[s], 1'b0);
                        n++;
                        queued_mask[s] = 1'b0;
                        remove_at(0);
                    end
                    if (n == 0) begin
                        push_result(ST_NO_EXPIRY, '0, '0, 1'b1);
                    end else begin
                        pending[pending.size() - 1].last = 1'b1;
                    end
                end
                OP_ADD: begin
                    if (req.delay_ticks == '0 || queued_mask[req.timer_slot]
                            || depth >= TIMER_SLOTS) begin
                        push_result(ST_REJECTED, '0, '0, 1'b1);
                        return;
                    end
                    rest = req.delay_ticks;
                    pos = 0;
                    // Walk past every entry that expires at the same time or earlier.
                    while (pos < depth) begin
                        s = order[pos];
                        if (rest < delta_of[s]) begin
                            delta_of[s] = delta_of[s] - rest;
                            break;
                        end
                        rest = rest - delta_of[s];
                        pos++;
                    end
                    for (int i = depth; i > pos; i--) begin
                        order[i] = order[i - 1];
                    end
                    order[pos] = req.timer_slot;
                    depth++;
                    delta_of[req.timer_slot] = rest;
                    owner_of[req.timer_slot] = req.owner_id;
                    queued_mask[req.timer_slot] = 1'b1;
                    push_result(ST_ADDED, '0, '0, 1'b1);
                end
                OP_DEL: begin
                    if (!queued_mask[req.timer_slot]) begin
                        push_result(ST_NOT_QUEUED, '0, '0, 1'b1);
                        return;
                    end
                    for (pos = 0; pos < depth; pos++) begin
                        if (order[pos] == req.timer_slot) break;
                    end
                    if (pos < depth) begin
                        // The successor inherits the removed delta.
                        if (pos + 1 < depth) begin
                            s = order[pos + 1];
                            delta_of[s] = delta_of[s] + delta_of[req.timer_slot];
                        end
                        remove_at(pos);
                    end
                    queued_mask[req.timer_slot] = 1'b0;
                    push_result(ST_REMOVED, '0, '0, 1'b1);
                end
                default: begin
                    push_result(ST_REJECTED, '0, '0, 1'b1);
                end
            endcase
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.expired_slot !== want.expired_slot)
                report_mismatch($sformatf("expired_slot %0d, expected %0d",
                                          got.expired_slot, want.expired_slot));
            if (got.wake_owner !== want.wake_owner)
                report_mismatch($sformatf("wake_owner %0d, expected %0d",
                                          got.wake_owner, want.wake_owner));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
        endtask
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_item;

    int src_idle_pct = 0;
    int rcv_stall_pct = 0;
    timer_queue_scoreboard sb = new();

    delta_list_timer_queue #(
        .TIMER_SLOTS(TIMER_SLOTS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_item);
        end
        m_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    function automatic in_item_t make_request(opcode_t op, logic [SLOT_W-1:0] slot,
                                              logic [DELTA_W-1:0] delay,
                                              logic [OWNER_W-1:0] owner);
        in_item_t r;
        r.opcode = op;
        r.timer_slot = slot;
        r.delay_ticks = delay;
        r.owner_id = owner;
        return r;
    endfunction

    task automatic send_request(in_item_t req);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
    endtask

    initial begin
        int pick;
        int dpick;
        opcode_t op;
        logic [DELTA_W-1:0] delay;
        logic [OWNER_W-1:0] owner;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty-queue cases, rejects, a full queue expiring at once.
        send_request(make_request(OP_TICK, 4'd0, 32'd0, 13'd0));
        send_request(make_request(OP_DEL, 4'd3, 32'd7, 13'd5));
        send_request(make_request(OP_RSVD, 4'd9, $urandom, 13'h1fff));
        send_request(make_request(OP_ADD, 4'd0, 32'd0, 13'd100));
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            owner = (i == 0) ? 13'd0 : (i == TIMER_SLOTS - 1) ? 13'h1fff : OWNER_W'($urandom);
            send_request(make_request(OP_ADD, i[SLOT_W-1:0], 32'd1, owner));
        end
        send_request(make_request(OP_ADD, 4'd15, 32'd9, 13'd1));
        send_request(make_request(OP_TICK, 4'd15, 32'hffff_ffff, 13'h1fff));
        send_request(make_request(OP_ADD, 4'd0, 32'hffff_ffff, 13'd0));
        send_request(make_request(OP_ADD, 4'd1, 32'd2, 13'h1fff));
        send_request(make_request(OP_DEL, 4'd1, 32'd0, 13'd0));
        send_request(make_request(OP_TICK, 4'd0, 32'd0, 13'd0));
        send_request(make_request(OP_DEL, 4'd0, 32'd0, 13'd0));

        // Random part in four traffic phases.
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            case (i / (RANDOM_REQUESTS / 4))
                0: begin src_idle_pct = 0; rcv_stall_pct = 0; end
                1: begin src_idle_pct = 53; rcv_stall_pct = 0; end
                2: begin src_idle_pct = 0; rcv_stall_pct = 53; end
                default: begin src_idle_pct = 14; rcv_stall_pct = 14; end
            endcase
            // Hold the sender off until the queue of outstanding results has drained.
            if (i == RANDOM_REQUESTS / 2) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (sb.pending.size() != 0);
            end
            pick = $urandom_range(99);
            if (pick < 38) op = OP_TICK;
            else if (pick < 72) op = OP_ADD;
            else if (pick < 92) op = OP_DEL;
            else op = OP_RSVD;
            delay = $urandom;
            if (op == OP_ADD) begin
                dpick = $urandom_range(99);
                if (dpick < 8) delay = '0;
                else if (dpick < 70) delay = $urandom_range(6, 1);
                else if (dpick < 85) delay = $urandom_range(40, 7);
            end
            send_request(make_request(op, SLOT_W'($urandom_range(TIMER_SLOTS - 1)), delay,
                                      OWNER_W'($urandom)));
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (sb.pending.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS delta_list_timer_queue");
        end else begin
            $display("FAIL delta_list_timer_queue");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL delta_list_timer_queue");
        $finish;
    end

endmodule
